// ===== rtl/core/motor_reply_line_parser_macros.svh =====
// Assertion macros for the motor reply line parser.
`ifndef MOTOR_REPLY_LINE_PARSER_MACROS_SVH
`define MOTOR_REPLY_LINE_PARSER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define MRLP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mrlp assertion failed");
// Next-cycle implication, disabled during reset.
`define MRLP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mrlp assertion failed");
`else
`define MRLP_ASSERT_NOW(label, clk, rst, ante, cons)
`define MRLP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/mrlp_pkg.sv =====
// Shared types and character constants for the motor reply line parser.
package mrlp_pkg;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FIELD = 2'd1,
      STATUS_TYPE  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      RTYPE_ERROR    = 2'd0,
      RTYPE_POSITION = 2'd1,
      RTYPE_SPEED    = 2'd2,
      RTYPE_UNKNOWN  = 2'd3
   } rtype_type;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UP_E  = 8'h45;
   localparam logic [7:0] CHAR_UP_P  = 8'h50;
   localparam logic [7:0] CHAR_UP_S  = 8'h53;
   localparam logic [7:0] CHAR_LO_E  = 8'h65;
   localparam logic [7:0] CHAR_LO_P  = 8'h70;
   localparam logic [7:0] CHAR_LO_S  = 8'h73;

   // Magnitude ceiling: 2^31, the size of the most negative value.
   localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
   localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

endpackage

// ===== rtl/core/mrlp_acc.sv =====
// Decimal accumulate: magnitude times ten plus one digit, saturated at 2^31.
module mrlp_acc (
   input  logic [31:0] mag,
   input  logic [3:0]  digit,
   output logic [31:0] mag_next
);

   logic [35:0] prod;

   // 10*m = 8*m + 2*m; m <= 2^31 so 36 bits never wrap
   assign prod = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0} + {32'd0, digit};

   assign mag_next = (prod > {4'd0, mrlp_pkg::MAG_LIMIT}) ? mrlp_pkg::MAG_LIMIT
                                                          : prod[31:0];

endmodule

// ===== rtl/core/motor_reply_line_parser.sv =====
// Top level of the motor reply line parser: byte register, parse state, result register.
//
// Parses reply lines "<channel digit>,<type letter><signed decimal>" from a byte
// stream, one byte per item on the req_ channel. CR or LF ends a line; a line end
// with no characters before it gives no result, every other line end gives exactly
// one result item on the rsp_ channel. Leading space/TAB/VT/FF before the channel
// digit and before the number are skipped; the type letter (e, p, s in either case)
// maps to error, position or speed. Text after the number is ignored, only the
// first MAX_LINE_CHARS characters of a line are examined, and a NUL byte ends the
// examined text. Status: 0 ok, 1 field syntax error (wins over a bad letter),
// 2 unknown type letter. When status is not ok, channel, type and value are 0.
// The value saturates to the 32-bit signed limits.
// Throughput is one byte per clock while the input side does not stall: each byte
// is captured in an input register, and then one pass of the parse logic (state
// update plus a multiply-by-ten accumulate) updates the line state and, on a line
// end, loads the result register that drives the rsp_ ports. The input side
// stalls only while a result waits in the output register and rsp_ready is low.
module motor_reply_line_parser #(
   parameter int MAX_LINE_CHARS = 63
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_line_ok,
   output logic [3:0]         rsp_channel,
   output logic [1:0]         rsp_reply_type,
   output logic signed [31:0] rsp_value,
   output logic [1:0]         rsp_status
);

`include "motor_reply_line_parser_macros.svh"

   localparam int CountW = $clog2(MAX_LINE_CHARS + 1);
   localparam logic [CountW-1:0] MaxCount = CountW'(MAX_LINE_CHARS);

   typedef enum logic [2:0] {
      PH_CHAN   = 3'd0,
      PH_COMMA  = 3'd1,
      PH_TYPE   = 3'd2,
      PH_NUM    = 3'd3,
      PH_SIGN   = 3'd4,
      PH_DIGITS = 3'd5,
      PH_FAIL   = 3'd6,
      PH_DONE   = 3'd7
   } phase_type;

   // input register
   logic       byte_valid_ff;
   logic [7:0] byte_ff;

   // line state
   phase_type           phase_ff, phase_in;
   logic [CountW-1:0]   count_ff, count_in;
   logic [3:0]          chan_ff, chan_in;
   mrlp_pkg::rtype_type type_ff, type_in;
   logic [31:0]         mag_ff, mag_in;
   logic                neg_ff, neg_in;

   // result register
   logic                 rsp_valid_ff;
   logic                 rsp_ok_ff;
   logic [3:0]           rsp_chan_ff;
   mrlp_pkg::rtype_type  rsp_type_ff;
   logic [31:0]          rsp_value_ff;
   mrlp_pkg::status_type rsp_status_ff;

   logic                 advance;
   logic                 emit;
   logic [31:0]          mag_acc;
   logic [31:0]          value_out;
   mrlp_pkg::status_type status_out;

   // byte classes
   logic is_eol, is_blank, is_digit, is_sign;
   logic [3:0] digit;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !byte_valid_ff || advance;

   assign is_eol   = (byte_ff == mrlp_pkg::CHAR_CR) || (byte_ff == mrlp_pkg::CHAR_LF);
   assign is_blank = (byte_ff == mrlp_pkg::CHAR_SPACE) || (byte_ff == mrlp_pkg::CHAR_TAB) ||
                     (byte_ff == mrlp_pkg::CHAR_VT) || (byte_ff == mrlp_pkg::CHAR_FF);
   assign is_digit = (byte_ff >= mrlp_pkg::CHAR_ZERO) && (byte_ff <= mrlp_pkg::CHAR_NINE);
   assign is_sign  = (byte_ff == mrlp_pkg::CHAR_PLUS) || (byte_ff == mrlp_pkg::CHAR_MINUS);
   assign digit    = byte_ff[3:0];

   mrlp_acc u_acc (
      .mag      (mag_ff),
      .digit    (digit),
      .mag_next (mag_acc)
   );

   // judgment of the line as it stands, used on a line end
   always_comb begin
      if (phase_ff != PH_DIGITS && phase_ff != PH_DONE) begin
         status_out = mrlp_pkg::STATUS_FIELD;
      end else if (type_ff == mrlp_pkg::RTYPE_UNKNOWN) begin
         status_out = mrlp_pkg::STATUS_TYPE;
      end else begin
         status_out = mrlp_pkg::STATUS_OK;
      end
      if (status_out != mrlp_pkg::STATUS_OK) begin
         value_out = 32'd0;
      end else if (neg_ff) begin
         value_out = 32'd0 - mag_ff;
      end else if (mag_ff >= mrlp_pkg::MAG_LIMIT) begin
         value_out = mrlp_pkg::POS_MAX;
      end else begin
         value_out = mag_ff;
      end
   end

   // next line state for the byte in the input register
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      chan_in  = chan_ff;
      type_in  = type_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      emit     = 1'b0;
      if (byte_valid_ff && advance) begin
         if (is_eol) begin
            // line end: a result unless the line was empty, then start over
            emit     = (count_ff != '0);
            phase_in = PH_CHAN;
            count_in = '0;
            chan_in  = 4'd0;
            type_in  = mrlp_pkg::RTYPE_ERROR;
            mag_in   = 32'd0;
            neg_in   = 1'b0;
         end else if (count_ff < MaxCount) begin
            count_in = count_ff + 1'b1;
            if (byte_ff == mrlp_pkg::CHAR_NUL) begin
               // NUL closes the examined text
               phase_in = (phase_ff == PH_DIGITS || phase_ff == PH_DONE) ? PH_DONE : PH_FAIL;
               count_in = MaxCount;
            end else begin
               unique case (phase_ff)
                  PH_CHAN: begin
                     if (is_digit) begin
                        chan_in  = digit;
                        phase_in = PH_COMMA;
                     end else if (!is_blank) begin
                        phase_in = PH_FAIL;
                     end
                  end
                  PH_COMMA: begin
                     phase_in = (byte_ff == mrlp_pkg::CHAR_COMMA) ? PH_TYPE : PH_FAIL;
                  end
                  PH_TYPE: begin
                     if (byte_ff == mrlp_pkg::CHAR_LO_E || byte_ff == mrlp_pkg::CHAR_UP_E) begin
                        type_in = mrlp_pkg::RTYPE_ERROR;
                     end else if (byte_ff == mrlp_pkg::CHAR_LO_P ||
                                  byte_ff == mrlp_pkg::CHAR_UP_P) begin
                        type_in = mrlp_pkg::RTYPE_POSITION;
                     end else if (byte_ff == mrlp_pkg::CHAR_LO_S ||
                                  byte_ff == mrlp_pkg::CHAR_UP_S) begin
                        type_in = mrlp_pkg::RTYPE_SPEED;
                     end else begin
                        type_in = mrlp_pkg::RTYPE_UNKNOWN;
                     end
                     phase_in = PH_NUM;
                  end
                  PH_NUM: begin
                     if (is_sign) begin
                        neg_in   = (byte_ff == mrlp_pkg::CHAR_MINUS);
                        phase_in = PH_SIGN;
                     end else if (is_digit) begin
                        mag_in   = mag_acc;
                        phase_in = PH_DIGITS;
                     end else if (!is_blank) begin
                        phase_in = PH_FAIL;
                     end
                  end
                  PH_SIGN: begin
                     if (is_digit) begin
                        mag_in   = mag_acc;
                        phase_in = PH_DIGITS;
                     end else begin
                        phase_in = PH_FAIL;
                     end
                  end
                  PH_DIGITS: begin
                     if (is_digit) begin
                        mag_in = mag_acc;
                     end else begin
                        phase_in = PH_DONE;
                     end
                  end
                  PH_FAIL, PH_DONE: begin
                     phase_in = phase_ff;
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         phase_ff      <= PH_CHAN;
         count_ff      <= '0;
         chan_ff       <= 4'd0;
         type_ff       <= mrlp_pkg::RTYPE_ERROR;
         mag_ff        <= 32'd0;
         neg_ff        <= 1'b0;
      end else begin
         if (req_ready) begin
            byte_valid_ff <= req_valid;
         end
         phase_ff <= phase_in;
         count_ff <= count_in;
         chan_ff  <= chan_in;
         type_ff  <= type_in;
         mag_ff   <= mag_in;
         neg_ff   <= neg_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      // payload registers
      if (req_valid && req_ready) begin
         byte_ff <= req_rx_byte;
      end
      if (emit) begin
         rsp_ok_ff     <= (status_out == mrlp_pkg::STATUS_OK);
         rsp_chan_ff   <= (status_out == mrlp_pkg::STATUS_OK) ? chan_ff : 4'd0;
         rsp_type_ff   <= (status_out == mrlp_pkg::STATUS_OK) ? type_ff
                                                              : mrlp_pkg::RTYPE_ERROR;
         rsp_value_ff  <= value_out;
         rsp_status_ff <= status_out;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_line_ok    = rsp_ok_ff;
   assign rsp_channel    = rsp_chan_ff;
   assign rsp_reply_type = rsp_type_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;

   `MRLP_ASSERT_NOW(a_ok_matches_status, clock, reset, rsp_valid_ff, rsp_ok_ff == (rsp_status_ff == mrlp_pkg::STATUS_OK))
   `MRLP_ASSERT_NOW(a_bad_line_zeroed, clock, reset, rsp_valid_ff && !rsp_ok_ff, rsp_chan_ff == 4'd0 && rsp_value_ff == 32'd0 && rsp_type_ff == mrlp_pkg::RTYPE_ERROR)
   `MRLP_ASSERT_NOW(a_count_bounded, clock, reset, 1'b1, count_ff <= MaxCount)
   `MRLP_ASSERT_NOW(a_fresh_line_clear, clock, reset, count_ff == '0, phase_ff == PH_CHAN && mag_ff == 32'd0 && !neg_ff)
   `MRLP_ASSERT_NEXT(a_emit_shows, clock, reset, emit, rsp_valid_ff)

endmodule
